// ----- hw/rtl/icac_pkg.sv -----
// shared types and constants for the int8 3x3 convolution accumulator
package icac_pkg;

    // kernel geometry
    localparam int KSIZE = 3;
    localparam int TAPS  = KSIZE * KSIZE;

    // field and register widths
    localparam int DATA_W   = 8;
    localparam int WIDX_W   = 13;
    localparam int ROW_W    = 16;
    localparam int OCOL_W   = 8;
    localparam int CFG_CH_W = 10;
    localparam int CFG_CO_W = 9;
    localparam int CFG_RO_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // output queue
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = 2;
    localparam int OQ_CW    = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNELS = 2'd0,
        CFG_OUT_COLS = 2'd1,
        CFG_OUT_ROWS = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        CMD_WEIGHT = 1'b0,
        CMD_SAMPLE = 1'b1
    } t_cmd;

    // control shared by every cell of the array
    typedef struct packed {
        logic acc_en;
        logic shift;
    } t_cell_ctrl;

    typedef struct packed {
        logic signed [DATA_W-1:0] result;
        logic [ROW_W-1:0]         out_row;
        logic [OCOL_W-1:0]        out_col;
        logic                     last;
    } t_result;

endpackage

// ----- hw/rtl/icac_if.sv -----
// request channel interfaces: sample input, result output, register writes
interface icac_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 command;
    logic [icac_pkg::WIDX_W-1:0]          weight_index;
    logic signed [icac_pkg::DATA_W-1:0]   value;
    modport source (output valid, command, weight_index, value, input ready);
    modport sink   (input valid, command, weight_index, value, output ready);
endinterface

interface icac_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [icac_pkg::DATA_W-1:0]   result;
    logic [icac_pkg::ROW_W-1:0]           out_row;
    logic [icac_pkg::OCOL_W-1:0]          out_col;
    logic                                 last;
    modport source (output valid, result, out_row, out_col, last, input ready);
    modport sink   (input valid, result, out_row, out_col, last, output ready);
endinterface

interface icac_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [icac_pkg::CFG_IDX_W-1:0]       index;
    logic [icac_pkg::CFG_DATA_W-1:0]      data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/icac_ram.sv -----
// generic single write port ram with registered read
module icac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hw/rtl/icac_cell.sv -----
// one tap cell: weight copy, product register and running sum
module icac_cell #(
    parameter int WDEPTH = 4608
) (
    input  logic                              i_clk,
    input  logic                              i_wr_en,
    input  logic [$clog2(WDEPTH)-1:0]         i_wr_addr,
    input  logic [icac_pkg::DATA_W-1:0]       i_wr_data,
    input  logic [$clog2(WDEPTH)-1:0]         i_rd_addr,
    input  logic [icac_pkg::DATA_W-1:0]       i_x,
    input  icac_pkg::t_cell_ctrl              i_ctrl,
    input  logic [icac_pkg::DATA_W-1:0]       i_shift_in,
    output logic [icac_pkg::DATA_W-1:0]       o_sum,
    output logic [icac_pkg::DATA_W-1:0]       o_total
);
    logic [icac_pkg::DATA_W-1:0]   w_weight;
    logic [2*icac_pkg::DATA_W-1:0] w_mul;
    logic [icac_pkg::DATA_W-1:0]   r_prod;
    logic [icac_pkg::DATA_W-1:0]   r_sum;
    logic [icac_pkg::DATA_W-1:0]   w_base;

    icac_ram #(
        .WIDTH (icac_pkg::DATA_W),
        .DEPTH (WDEPTH)
    ) u_wram (
        .i_clk   (i_clk),
        .i_we    (i_wr_en),
        .i_waddr (i_wr_addr),
        .i_wdata (i_wr_data),
        .i_raddr (i_rd_addr),
        .o_rdata (w_weight)
    );

    // product wraps to 8 bits, so unsigned low bits are enough
    assign w_mul = w_weight * i_x;

    always_ff @(posedge i_clk) begin
        r_prod <= w_mul[icac_pkg::DATA_W-1:0];
    end

    // a new pixel takes the neighbor's sum, otherwise keep accumulating
    always_comb begin
        w_base  = i_ctrl.shift ? i_shift_in : r_sum;
        o_total = w_base + r_prod;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.acc_en) begin
            r_sum <= o_total;
        end
    end

    assign o_sum = r_sum;
endmodule

// ----- hw/rtl/int8_conv3x3_channel_accumulate.sv -----
// top level: 3x3 int8 convolution over channel-interleaved samples
// pipeline: a sample request's result passes the stage 1 and stage 2 registers before it enters
// the output queue, and can be taken from the following cycle on
// throughput: one request per cycle while the queue has room; the 3x3 cell array and a 4-entry
// output queue take a new request while results wait to be taken, until queued results plus requests in flight reach 4
// reset sets configuration registers to 1 and clears stage valids, position counters and queue; weights stay undefined
module int8_conv3x3_channel_accumulate #(
    parameter int MAX_CHANNELS = 512,
    parameter int MAX_COLS     = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    icac_in_if.sink     i_in,
    icac_out_if.source  o_out,
    icac_cfg_if.sink    i_cfg
);
    localparam int WDEPTH = icac_pkg::TAPS * MAX_CHANNELS;
    localparam int WAW    = $clog2(WDEPTH);
    localparam int CHW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int ECW    = $clog2(MAX_CHANNELS + 1);
    localparam int CAW    = $clog2(MAX_COLS);
    localparam int COLW   = $clog2(MAX_COLS + 2);
    localparam int ECOLW  = $clog2(MAX_COLS + 1);
    localparam int RW     = icac_pkg::ROW_W + 1;
    localparam int DW     = icac_pkg::DATA_W;

    // configuration registers
    logic [icac_pkg::CFG_CH_W-1:0] r_cfg_ch;
    logic [icac_pkg::CFG_CO_W-1:0] r_cfg_cols;
    logic [icac_pkg::CFG_RO_W-1:0] r_cfg_rows;
    logic [ECW-1:0]                w_eff_ch;
    logic [ECOLW-1:0]              w_eff_cols;
    logic [icac_pkg::ROW_W-1:0]    w_eff_rows;
    logic                          w_cfg_fire;
    logic                          w_cfg_hit;

    // position counters
    logic [CHW-1:0]  r_chan;
    logic [COLW-1:0] r_col;
    logic [RW-1:0]   r_row;
    logic            w_ch_end;
    logic            w_col_end;
    logic            w_row_end;

    logic w_in_fire;
    logic w_sample;
    logic w_wr_en;

    // pipeline stage 1
    logic                       r_v1;
    logic [DW-1:0]              r_x1;
    logic                       r_first1;
    logic                       r_lastch1;
    logic                       r_cge1;
    logic                       r_rge1;
    logic [CAW-1:0]             r_rcol1;
    logic [CAW-1:0]             r_wcol1;
    logic [icac_pkg::ROW_W-1:0] r_orow1;
    logic [icac_pkg::OCOL_W-1:0] r_ocol1;
    logic                       r_flast1;

    // pipeline stage 2
    logic                       r_v2;
    logic                       r_first2;
    logic                       r_lastch2;
    logic                       r_cge2;
    logic                       r_rge2;
    logic [CAW-1:0]             r_wcol2;
    logic [icac_pkg::ROW_W-1:0] r_orow2;
    logic [icac_pkg::OCOL_W-1:0] r_ocol2;
    logic                       r_flast2;
    logic [DW-1:0]              r_init1;
    logic [DW-1:0]              r_init2;

    // line buffers and write forwarding
    logic           w_line_we;
    logic [DW-1:0]  w_lineA_rd;
    logic [DW-1:0]  w_lineB_rd;
    logic           r_lw_en;
    logic [CAW-1:0] r_lw_addr;
    logic [DW-1:0]  r_lw_a;
    logic [DW-1:0]  r_lw_b;
    logic [DW-1:0]  n_init1;
    logic [DW-1:0]  n_init2;

    // cell array
    icac_pkg::t_cell_ctrl w_ctrl;
    logic [WAW-1:0] w_rd_addr [icac_pkg::TAPS];
    logic [DW-1:0]  w_sum     [icac_pkg::TAPS];
    logic [DW-1:0]  w_total   [icac_pkg::TAPS];
    logic [DW-1:0]  w_shin    [icac_pkg::TAPS];

    // output queue
    icac_pkg::t_result              r_oq [icac_pkg::OQ_DEPTH];
    logic [icac_pkg::OQ_AW-1:0]     r_wptr;
    logic [icac_pkg::OQ_AW-1:0]     r_rptr;
    logic [icac_pkg::OQ_CW-1:0]     r_count;
    logic                           w_push;
    logic                           w_pop;
    icac_pkg::t_result              w_res;

    // effective register values after saturation
    always_comb begin
        if (r_cfg_ch == '0) begin
            w_eff_ch = ECW'(1);
        end else if (32'(r_cfg_ch) > 32'(MAX_CHANNELS)) begin
            w_eff_ch = ECW'(MAX_CHANNELS);
        end else begin
            w_eff_ch = ECW'(r_cfg_ch);
        end
        if (r_cfg_cols == '0) begin
            w_eff_cols = ECOLW'(1);
        end else if (32'(r_cfg_cols) > 32'(MAX_COLS)) begin
            w_eff_cols = ECOLW'(MAX_COLS);
        end else begin
            w_eff_cols = ECOLW'(r_cfg_cols);
        end
        w_eff_rows = (r_cfg_rows == '0) ? icac_pkg::ROW_W'(1) : r_cfg_rows;
    end

    // handshakes
    assign i_cfg.ready = 1'b1;
    assign w_cfg_fire  = i_cfg.valid;
    assign w_cfg_hit   = w_cfg_fire && (i_cfg.index == icac_pkg::CFG_CHANNELS ||
                                        i_cfg.index == icac_pkg::CFG_OUT_COLS ||
                                        i_cfg.index == icac_pkg::CFG_OUT_ROWS);
    assign i_in.ready  = (32'(r_count) + 32'(r_v1) + 32'(r_v2)) < icac_pkg::OQ_DEPTH;
    assign w_in_fire   = i_in.valid && i_in.ready;
    assign w_sample    = w_in_fire && (i_in.command == icac_pkg::CMD_SAMPLE);
    assign w_wr_en     = w_in_fire && (i_in.command == icac_pkg::CMD_WEIGHT) &&
                         (32'(i_in.weight_index) < WDEPTH);

    // counter wrap points
    assign w_ch_end  = (32'(r_chan) == 32'(w_eff_ch) - 1);
    assign w_col_end = (32'(r_col) == 32'(w_eff_cols) + 1);
    assign w_row_end = (32'(r_row) == 32'(w_eff_rows) + 1);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ch   <= icac_pkg::CFG_CH_W'(1);
            r_cfg_cols <= icac_pkg::CFG_CO_W'(1);
            r_cfg_rows <= icac_pkg::CFG_RO_W'(1);
        end else if (w_cfg_fire) begin
            unique case (i_cfg.index)
                icac_pkg::CFG_CHANNELS: r_cfg_ch   <= i_cfg.data[icac_pkg::CFG_CH_W-1:0];
                icac_pkg::CFG_OUT_COLS: r_cfg_cols <= i_cfg.data[icac_pkg::CFG_CO_W-1:0];
                icac_pkg::CFG_OUT_ROWS: r_cfg_rows <= i_cfg.data[icac_pkg::CFG_RO_W-1:0];
                default: ;
            endcase
        end
    end

    // position of the next sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_cfg_hit) begin
            r_chan <= '0;
            r_col  <= '0;
            r_row  <= '0;
        end else if (w_sample) begin
            if (w_ch_end) begin
                r_chan <= '0;
                if (w_col_end) begin
                    r_col <= '0;
                    r_row <= w_row_end ? '0 : r_row + RW'(1);
                end else begin
                    r_col <= r_col + COLW'(1);
                end
            end else begin
                r_chan <= r_chan + CHW'(1);
            end
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_lw_en <= 1'b0;
        end else begin
            r_v1    <= w_sample;
            r_v2    <= r_v1;
            r_lw_en <= w_line_we;
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        r_x1      <= i_in.value;
        r_first1  <= (r_chan == '0);
        r_lastch1 <= w_ch_end;
        r_cge1    <= (r_col >= COLW'(2));
        r_rge1    <= (r_row >= RW'(2));
        r_rcol1   <= CAW'(r_col);
        r_wcol1   <= CAW'(r_col - COLW'(2));
        r_orow1   <= icac_pkg::ROW_W'(r_row - RW'(2));
        r_ocol1   <= icac_pkg::OCOL_W'(r_col - COLW'(2));
        r_flast1  <= w_col_end && w_row_end;
    end

    // line data with forwarding of writes the read missed
    always_comb begin
        if (w_line_we && r_wcol2 == r_rcol1) begin
            n_init1 = w_total[2];
            n_init2 = w_total[5];
        end else if (r_lw_en && r_lw_addr == r_rcol1) begin
            n_init1 = r_lw_a;
            n_init2 = r_lw_b;
        end else begin
            n_init1 = w_lineA_rd;
            n_init2 = w_lineB_rd;
        end
    end

    // stage 2 payload
    always_ff @(posedge i_clk) begin
        r_first2  <= r_first1;
        r_lastch2 <= r_lastch1;
        r_cge2    <= r_cge1;
        r_rge2    <= r_rge1;
        r_wcol2   <= r_wcol1;
        r_orow2   <= r_orow1;
        r_ocol2   <= r_ocol1;
        r_flast2  <= r_flast1;
        r_init1   <= n_init1;
        r_init2   <= n_init2;
        r_lw_addr <= r_wcol2;
        r_lw_a    <= w_total[2];
        r_lw_b    <= w_total[5];
    end

    // finished row partials go to the line buffers
    assign w_line_we = r_v2 && r_lastch2 && r_cge2;

    icac_ram #(.WIDTH(DW), .DEPTH(MAX_COLS)) u_line_a (
        .i_clk   (i_clk),
        .i_we    (w_line_we),
        .i_waddr (r_wcol2),
        .i_wdata (w_total[2]),
        .i_raddr (CAW'(r_col)),
        .o_rdata (w_lineA_rd)
    );

    icac_ram #(.WIDTH(DW), .DEPTH(MAX_COLS)) u_line_b (
        .i_clk   (i_clk),
        .i_we    (w_line_we),
        .i_waddr (r_wcol2),
        .i_wdata (w_total[5]),
        .i_raddr (CAW'(r_col)),
        .o_rdata (w_lineB_rd)
    );

    // 3x3 cell array: lanes by kernel row, chain by kernel column
    assign w_ctrl.acc_en = r_v2;
    assign w_ctrl.shift  = r_first2;

    for (genvar t = 0; t < icac_pkg::TAPS; t++) begin : g_cell
        assign w_rd_addr[t] = WAW'(t) * WAW'(w_eff_ch) + WAW'(r_chan);
        if (t % icac_pkg::KSIZE != 0) begin : g_chain
            assign w_shin[t] = w_sum[t-1];
        end else if (t == 0) begin : g_lane0
            assign w_shin[t] = '0;
        end else if (t == icac_pkg::KSIZE) begin : g_lane1
            assign w_shin[t] = r_init1;
        end else begin : g_lane2
            assign w_shin[t] = r_init2;
        end

        icac_cell #(.WDEPTH(WDEPTH)) u_cell (
            .i_clk      (i_clk),
            .i_wr_en    (w_wr_en),
            .i_wr_addr  (WAW'(i_in.weight_index)),
            .i_wr_data  (i_in.value),
            .i_rd_addr  (w_rd_addr[t]),
            .i_x        (r_x1),
            .i_ctrl     (w_ctrl),
            .i_shift_in (w_shin[t]),
            .o_sum      (w_sum[t]),
            .o_total    (w_total[t])
        );
    end

    // output queue
    assign w_push = r_v2 && r_lastch2 && r_cge2 && r_rge2;
    assign w_pop  = o_out.valid && o_out.ready;

    always_comb begin
        w_res.result  = w_total[icac_pkg::TAPS-1];
        w_res.out_row = r_orow2;
        w_res.out_col = r_ocol2;
        w_res.last    = r_flast2;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_oq[r_wptr] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + icac_pkg::OQ_AW'(1);
            end
            if (w_pop) begin
                r_rptr <= r_rptr + icac_pkg::OQ_AW'(1);
            end
            r_count <= r_count + icac_pkg::OQ_CW'(w_push) - icac_pkg::OQ_CW'(w_pop);
        end
    end

    assign o_out.valid   = (r_count != '0);
    assign o_out.result  = r_oq[r_rptr].result;
    assign o_out.out_row = r_oq[r_rptr].out_row;
    assign o_out.out_col = r_oq[r_rptr].out_col;
    assign o_out.last    = r_oq[r_rptr].last;
endmodule
